// File: src/twra_pkg.sv
`timescale 1ns / 1ps

package twra_pkg;

   // Fixed field widths.
   localparam int DATA_W  = 64;
   localparam int INDEX_W = 11;
   localparam int FUNC_W  = 2;

   // Positions run up to the largest element count plus one.
   localparam int POS_W = 17;
   // Tree walk cursor, wide enough to step past the last node.
   localparam int WALK_W = POS_W + 1;

   // Reset value of the element count register.
   localparam logic [INDEX_W-1:0] ELEM_COUNT_RESET = 11'd1024;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

   // Work queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Work kinds handed from the front to the back.
   typedef enum logic [2:0] {
      JOB_CLEAR,
      JOB_LOAD,
      JOB_ADD,
      JOB_QUERY,
      JOB_QZERO
   } job_kind_type;

   typedef struct packed {
      job_kind_type      kind;
      logic [POS_W-1:0]  lo;
      logic [POS_W-1:0]  hi;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] slope;
      logic [DATA_W-1:0] op;
   } job_type;

endpackage

// File: src/time_weighted_range_add_sum_tree.sv
`timescale 1ns / 1ps

// The time of a range add or a query is set by the shared multiply and two node walks.
// One request is worked at a time; two more wait in the queue behind the front part.
// Clear and reset both sweep the tree memories; after reset no request is taken until
// that sweep ends. Reset is synchronous, active high.
module time_weighted_range_add_sum_tree #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [twra_pkg::INDEX_W-1:0] csr_element_count,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [twra_pkg::FUNC_W-1:0]  req_func,
   input  logic [twra_pkg::INDEX_W-1:0] req_left_index,
   input  logic [twra_pkg::INDEX_W-1:0] req_right_index,
   input  logic [twra_pkg::DATA_W-1:0]  req_add_value,
   input  logic [twra_pkg::DATA_W-1:0]  req_init_slope,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [twra_pkg::DATA_W-1:0]  rsp_range_total
);

   logic [twra_pkg::INDEX_W-1:0] element_count_ff;
   logic [twra_pkg::POS_W-1:0]   size_in_use;
   logic                         push;
   twra_pkg::job_type            push_job;
   logic                         pop;
   twra_pkg::job_type            head_job;
   logic                         queue_full;
   logic                         queue_empty;
   logic                         init_busy;

   // Element count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= twra_pkg::ELEM_COUNT_RESET;
      end else if (csr_write_enable) begin
         element_count_ff <= csr_element_count;
      end
   end

   // Effective size, saturated at MAX_ELEMENTS.
   assign size_in_use =
      (twra_pkg::POS_W'(element_count_ff) > twra_pkg::POS_W'(MAX_ELEMENTS))
         ? twra_pkg::POS_W'(MAX_ELEMENTS) : twra_pkg::POS_W'(element_count_ff);

   twra_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_func        (req_func),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .req_add_value   (req_add_value),
      .req_init_slope  (req_init_slope),
      .size_in_use     (size_in_use),
      .queue_full      (queue_full),
      .init_busy       (init_busy),
      .req_stall       (req_stall),
      .push            (push),
      .push_job        (push_job)
   );

   twra_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   twra_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_ready       (!queue_empty),
      .job             (head_job),
      .job_pop         (pop),
      .size_in_use     (size_in_use),
      .init_busy       (init_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_total (rsp_range_total)
   );

endmodule

// File: src/twra_mul.sv
`timescale 1ns / 1ps

module twra_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [twra_pkg::DATA_W-1:0] a,
   input  logic [twra_pkg::DATA_W-1:0] b,
   output logic                        done,
   output logic [twra_pkg::DATA_W-1:0] product
);

   localparam int HALF_W = twra_pkg::DATA_W / 2;

   logic [2:0]                  step_ff;
   logic [twra_pkg::DATA_W-1:0] a_ff;
   logic [twra_pkg::DATA_W-1:0] b_ff;
   logic [twra_pkg::DATA_W-1:0] part_ff;
   logic [twra_pkg::DATA_W-1:0] acc_ff;
   logic [HALF_W-1:0]           mx;
   logic [HALF_W-1:0]           my;

   // Operand halves for the shared 32x32 multiplier: low*low, low*high, high*low.
   always_comb begin
      mx = a_ff[HALF_W-1:0];
      my = b_ff[HALF_W-1:0];
      case (step_ff)
         3'd2: my = b_ff[twra_pkg::DATA_W-1:HALF_W];
         3'd3: mx = a_ff[twra_pkg::DATA_W-1:HALF_W];
         default: ;
      endcase
   end

   // Partial products are registered, then summed modulo 2^64.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else begin
         case (step_ff)
            3'd0: begin
               if (go) begin
                  a_ff    <= a;
                  b_ff    <= b;
                  step_ff <= 3'd1;
               end
            end
            3'd1: begin
               part_ff <= mx * my;
               step_ff <= 3'd2;
            end
            3'd2: begin
               part_ff <= mx * my;
               acc_ff  <= part_ff;
               step_ff <= 3'd3;
            end
            3'd3: begin
               part_ff <= mx * my;
               acc_ff  <= acc_ff + {part_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               step_ff <= 3'd4;
            end
            3'd4: begin
               acc_ff  <= acc_ff + {part_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               step_ff <= 3'd5;
            end
            default: step_ff <= 3'd0;
         endcase
      end
   end

   assign done    = (step_ff == 3'd5);
   assign product = acc_ff;

endmodule

// File: src/twra_queue.sv
`timescale 1ns / 1ps

module twra_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  twra_pkg::job_type push_job,
   input  logic              pop,
   output twra_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);

   twra_pkg::job_type                   slot_ff [twra_pkg::QUEUE_DEPTH];
   logic [twra_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [twra_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [twra_pkg::QCNT_W-1:0]         count_ff;
   logic                                do_push;
   logic                                do_pop;

   assign full     = (count_ff == twra_pkg::QCNT_W'(twra_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   // Slot storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: src/twra_front.sv
`timescale 1ns / 1ps

module twra_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [twra_pkg::FUNC_W-1:0]  req_func,
   input  logic [twra_pkg::INDEX_W-1:0] req_left_index,
   input  logic [twra_pkg::INDEX_W-1:0] req_right_index,
   input  logic [twra_pkg::DATA_W-1:0]  req_add_value,
   input  logic [twra_pkg::DATA_W-1:0]  req_init_slope,
   input  logic [twra_pkg::POS_W-1:0]   size_in_use,
   input  logic                         queue_full,
   input  logic                         init_busy,
   output logic                         req_stall,
   output logic                         push,
   output twra_pkg::job_type            push_job
);

   logic [twra_pkg::DATA_W-1:0] op_count_ff;
   logic [twra_pkg::DATA_W-1:0] op_count_in;
   logic [twra_pkg::POS_W-1:0]  lo_raw;
   logic [twra_pkg::POS_W-1:0]  hi_raw;
   logic [twra_pkg::POS_W-1:0]  lo_clamp;
   logic [twra_pkg::POS_W-1:0]  hi_clamp;
   logic                        accept;
   logic                        wants_back;

   assign req_stall = queue_full || init_busy;
   assign accept    = req_valid && !req_stall;

   // Clamp the interval to the elements in use.
   assign lo_raw   = twra_pkg::POS_W'(req_left_index);
   assign hi_raw   = twra_pkg::POS_W'(req_right_index);
   assign lo_clamp = (lo_raw == '0) ? twra_pkg::POS_W'(1) : lo_raw;
   assign hi_clamp = (hi_raw > size_in_use) ? size_in_use : hi_raw;

   // Classify the request and stamp it with its operation number.
   always_comb begin
      op_count_in        = op_count_ff;
      wants_back         = 1'b0;
      push_job.kind      = twra_pkg::JOB_CLEAR;
      push_job.lo        = lo_clamp;
      push_job.hi        = hi_clamp;
      push_job.value     = req_add_value;
      push_job.slope     = req_init_slope;
      push_job.op        = op_count_ff + 1'b1;
      unique case (req_func)
         twra_pkg::FUNC_CLEAR: begin
            op_count_in = '0;
            wants_back  = 1'b1;
         end
         twra_pkg::FUNC_LOAD: begin
            push_job.kind = twra_pkg::JOB_LOAD;
            push_job.lo   = lo_raw;
            wants_back    = (lo_raw != '0) && (lo_raw <= size_in_use);
         end
         twra_pkg::FUNC_ADD: begin
            op_count_in   = op_count_ff + 1'b1;
            push_job.kind = twra_pkg::JOB_ADD;
            wants_back    = (lo_clamp <= hi_clamp);
         end
         twra_pkg::FUNC_QUERY: begin
            op_count_in   = op_count_ff + 1'b1;
            push_job.kind = (lo_clamp <= hi_clamp) ? twra_pkg::JOB_QUERY
                                                   : twra_pkg::JOB_QZERO;
            wants_back    = 1'b1;
         end
         default: ;
      endcase
   end

   assign push = accept && wants_back;

   // Operation counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_count_ff <= '0;
      end else if (accept) begin
         op_count_ff <= op_count_in;
      end
   end

endmodule

// File: src/twra_back.sv
`timescale 1ns / 1ps

module twra_back #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_ready,
   input  twra_pkg::job_type           job,
   output logic                        job_pop,
   input  logic [twra_pkg::POS_W-1:0]  size_in_use,
   output logic                        init_busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [twra_pkg::DATA_W-1:0] rsp_range_total
);

   localparam int DEPTH = MAX_ELEMENTS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = twra_pkg::DATA_W;
   localparam int KW    = twra_pkg::WALK_W;

   typedef enum logic [4:0] {
      S_SWEEP, S_IDLE, S_LD_RD, S_LD_WR,
      S_ADD_TV, S_ADD_P1, S_ADD_P2, S_ADD_P3, S_ADD_P4,
      S_WALK_RD, S_WALK_WR,
      S_Q_PH, S_Q_PL, S_Q_PX, S_QW_RD, S_QW_AC,
      S_QM1, S_QM2, S_QM3, S_QM4, S_QM5, S_QM6,
      S_OUT
   } state_type;

   state_type          state_ff;
   twra_pkg::job_type  job_ff;
   logic [AW-1:0]      sweep_addr_ff;
   logic               init_ff;
   logic               issued_ff;
   logic               second_ff;
   logic [KW-1:0]      k_ff;
   logic [DW-1:0]      tv_ff;
   logic [DW-1:0]      inc_cp_ff;
   logic [DW-1:0]      inc_wp_ff;
   logic [DW-1:0]      inc_ct_ff;
   logic [DW-1:0]      inc_wt_ff;
   logic [DW-1:0]      base_ff;
   logic [DW-1:0]      grow_ff;
   logic [DW-1:0]      cacc_p_ff;
   logic [DW-1:0]      cacc_t_ff;
   logic [DW-1:0]      chi_p_ff;
   logic [DW-1:0]      chi_t_ff;
   logic [DW-1:0]      wd_p_ff;
   logic [DW-1:0]      wd_t_ff;
   logic [DW-1:0]      s1_ff;
   logic [DW-1:0]      s2_ff;
   logic [DW-1:0]      tot_ff;
   logic               rsp_valid_ff;
   logic [DW-1:0]      rsp_total_ff;

   // Memories: prefix sums and the four tree arrays.
   logic [DW-1:0]      pre_init_mem [DEPTH];
   logic [DW-1:0]      pre_slope_mem [DEPTH];
   logic [DW-1:0]      cp_mem [DEPTH];
   logic [DW-1:0]      wp_mem [DEPTH];
   logic [DW-1:0]      ct_mem [DEPTH];
   logic [DW-1:0]      wt_mem [DEPTH];
   logic [DW-1:0]      pi_rd_ff;
   logic [DW-1:0]      ps_rd_ff;
   logic [DW-1:0]      cp_rd_ff;
   logic [DW-1:0]      wp_rd_ff;
   logic [DW-1:0]      ct_rd_ff;
   logic [DW-1:0]      wt_rd_ff;

   logic [twra_pkg::POS_W-1:0] lo;
   logic [twra_pkg::POS_W-1:0] hi;
   logic [twra_pkg::POS_W-1:0] hi1;
   logic [twra_pkg::POS_W-1:0] lo_m1;
   logic [KW-1:0]              k_low;
   logic [KW-1:0]              n_wide;
   logic [AW-1:0]              p_raddr;
   logic [AW-1:0]              t_addr;
   logic                       t_we;
   logic                       sweeping;
   logic                       is_mul;
   logic                       mul_go;
   logic                       mul_done;
   logic [DW-1:0]              mul_a;
   logic [DW-1:0]              mul_b;
   logic [DW-1:0]              mul_p;
   logic                       out_free;

   assign lo       = job_ff.lo;
   assign hi       = job_ff.hi;
   assign hi1      = hi + 1'b1;
   assign lo_m1    = lo - 1'b1;
   assign k_low    = k_ff & (~k_ff + 1'b1);
   assign n_wide   = KW'(size_in_use);
   assign sweeping = (state_ff == S_SWEEP);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Shared multiplier operands per step.
   always_comb begin
      is_mul = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_ADD_TV: begin mul_a = job_ff.op;  mul_b = job_ff.value; end
         S_ADD_P1: begin mul_a = DW'(lo);    mul_b = job_ff.value; end
         S_ADD_P2: begin mul_a = DW'(lo);    mul_b = tv_ff;        end
         S_ADD_P3: begin mul_a = DW'(hi1);   mul_b = job_ff.value; end
         S_ADD_P4: begin mul_a = DW'(hi1);   mul_b = tv_ff;        end
         S_QM1:    begin mul_a = DW'(hi1);   mul_b = chi_p_ff;     end
         S_QM2:    begin mul_a = DW'(lo);    mul_b = cacc_p_ff;    end
         S_QM3:    begin mul_a = DW'(hi1);   mul_b = chi_t_ff;     end
         S_QM4:    begin mul_a = DW'(lo);    mul_b = cacc_t_ff;    end
         S_QM5:    begin mul_a = job_ff.op;  mul_b = grow_ff;      end
         S_QM6:    begin mul_a = job_ff.op;  mul_b = s1_ff;        end
         default:  is_mul = 1'b0;
      endcase
   end

   assign mul_go = is_mul && !issued_ff;

   twra_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // Prefix memory addressing.
   assign p_raddr = (state_ff == S_Q_PH) ? hi[AW-1:0] : lo_m1[AW-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == S_LD_WR) begin
         pre_init_mem[lo[AW-1:0]]  <= ((lo_m1 == '0) ? '0 : pi_rd_ff) + job_ff.value;
         pre_slope_mem[lo[AW-1:0]] <= ((lo_m1 == '0) ? '0 : ps_rd_ff) + job_ff.slope;
      end
      pi_rd_ff <= pre_init_mem[p_raddr];
      ps_rd_ff <= pre_slope_mem[p_raddr];
   end

   // Tree memories: cleared by the sweep, updated read-modify-write on a walk.
   assign t_addr = sweeping ? sweep_addr_ff : k_ff[AW-1:0];
   assign t_we   = sweeping || (state_ff == S_WALK_WR);

   always_ff @(posedge clock) begin
      if (t_we) begin
         cp_mem[t_addr] <= sweeping ? '0 : cp_rd_ff + inc_cp_ff;
         wp_mem[t_addr] <= sweeping ? '0 : wp_rd_ff + inc_wp_ff;
         ct_mem[t_addr] <= sweeping ? '0 : ct_rd_ff + inc_ct_ff;
         wt_mem[t_addr] <= sweeping ? '0 : wt_rd_ff + inc_wt_ff;
      end
      cp_rd_ff <= cp_mem[t_addr];
      wp_rd_ff <= wp_mem[t_addr];
      ct_rd_ff <= ct_mem[t_addr];
      wt_rd_ff <= wt_mem[t_addr];
   end

   assign job_pop = (state_ff == S_IDLE) && job_ready;

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_addr_ff <= '0;
         init_ff       <= 1'b1;
         issued_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The output stage reloads itself in S_OUT, so only drop it elsewhere.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_go) begin
            issued_ff <= 1'b1;
         end
         if (mul_done) begin
            issued_ff <= 1'b0;
         end
         unique case (state_ff)
            S_SWEEP: begin
               if (sweep_addr_ff == AW'(MAX_ELEMENTS)) begin
                  init_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end else begin
                  sweep_addr_ff <= sweep_addr_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (job_ready) begin
                  job_ff <= job;
                  unique case (job.kind)
                     twra_pkg::JOB_CLEAR: begin
                        sweep_addr_ff <= '0;
                        state_ff      <= S_SWEEP;
                     end
                     twra_pkg::JOB_LOAD:  state_ff <= S_LD_RD;
                     twra_pkg::JOB_ADD:   state_ff <= S_ADD_TV;
                     twra_pkg::JOB_QUERY: state_ff <= S_Q_PH;
                     twra_pkg::JOB_QZERO: begin
                        tot_ff   <= '0;
                        state_ff <= S_OUT;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_LD_RD: state_ff <= S_LD_WR;
            S_LD_WR: state_ff <= S_IDLE;
            S_ADD_TV: begin
               if (mul_done) begin
                  tv_ff    <= mul_p;
                  state_ff <= S_ADD_P1;
               end
            end
            S_ADD_P1: begin
               if (mul_done) begin
                  inc_wp_ff <= mul_p;
                  state_ff  <= S_ADD_P2;
               end
            end
            S_ADD_P2: begin
               if (mul_done) begin
                  inc_wt_ff <= mul_p;
                  inc_cp_ff <= job_ff.value;
                  inc_ct_ff <= tv_ff;
                  k_ff      <= KW'(lo);
                  second_ff <= 1'b0;
                  state_ff  <= S_WALK_RD;
               end
            end
            S_ADD_P3: begin
               if (mul_done) begin
                  inc_wp_ff <= '0 - mul_p;
                  inc_cp_ff <= '0 - job_ff.value;
                  inc_ct_ff <= '0 - tv_ff;
                  state_ff  <= S_ADD_P4;
               end
            end
            S_ADD_P4: begin
               if (mul_done) begin
                  inc_wt_ff <= '0 - mul_p;
                  k_ff      <= KW'(hi1);
                  second_ff <= 1'b1;
                  state_ff  <= S_WALK_RD;
               end
            end
            S_WALK_RD: begin
               if (k_ff > n_wide) begin
                  state_ff <= second_ff ? S_IDLE : S_ADD_P3;
               end else begin
                  state_ff <= S_WALK_WR;
               end
            end
            S_WALK_WR: begin
               k_ff     <= k_ff + k_low;
               state_ff <= S_WALK_RD;
            end
            S_Q_PH: state_ff <= S_Q_PL;
            S_Q_PL: begin
               base_ff  <= pi_rd_ff;
               grow_ff  <= ps_rd_ff;
               state_ff <= S_Q_PX;
            end
            S_Q_PX: begin
               if (lo_m1 != '0) begin
                  base_ff <= base_ff - pi_rd_ff;
                  grow_ff <= grow_ff - ps_rd_ff;
               end
               k_ff      <= KW'(hi);
               cacc_p_ff <= '0;
               cacc_t_ff <= '0;
               wd_p_ff   <= '0;
               wd_t_ff   <= '0;
               second_ff <= 1'b0;
               state_ff  <= S_QW_RD;
            end
            S_QW_RD: begin
               if (k_ff == '0) begin
                  if (!second_ff) begin
                     chi_p_ff  <= cacc_p_ff;
                     chi_t_ff  <= cacc_t_ff;
                     cacc_p_ff <= '0;
                     cacc_t_ff <= '0;
                     k_ff      <= KW'(lo_m1);
                     second_ff <= 1'b1;
                  end else begin
                     state_ff <= S_QM1;
                  end
               end else begin
                  state_ff <= S_QW_AC;
               end
            end
            S_QW_AC: begin
               cacc_p_ff <= cacc_p_ff + cp_rd_ff;
               cacc_t_ff <= cacc_t_ff + ct_rd_ff;
               wd_p_ff   <= second_ff ? wd_p_ff - wp_rd_ff : wd_p_ff + wp_rd_ff;
               wd_t_ff   <= second_ff ? wd_t_ff - wt_rd_ff : wd_t_ff + wt_rd_ff;
               k_ff      <= k_ff - k_low;
               state_ff  <= S_QW_RD;
            end
            S_QM1: begin
               if (mul_done) begin
                  s1_ff    <= mul_p - wd_p_ff;
                  state_ff <= S_QM2;
               end
            end
            S_QM2: begin
               if (mul_done) begin
                  s1_ff    <= s1_ff - mul_p;
                  state_ff <= S_QM3;
               end
            end
            S_QM3: begin
               if (mul_done) begin
                  s2_ff    <= mul_p - wd_t_ff;
                  state_ff <= S_QM4;
               end
            end
            S_QM4: begin
               if (mul_done) begin
                  s2_ff    <= s2_ff - mul_p;
                  state_ff <= S_QM5;
               end
            end
            S_QM5: begin
               if (mul_done) begin
                  tot_ff   <= base_ff - s2_ff + mul_p;
                  state_ff <= S_QM6;
               end
            end
            S_QM6: begin
               if (mul_done) begin
                  tot_ff   <= tot_ff + mul_p;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_total_ff <= tot_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign init_busy       = init_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = rsp_total_ff;

   // A product only arrives for a multiply that was started.
   assert property (@(posedge clock) disable iff (reset) mul_done |-> issued_ff)
      else $error("multiplier result without a pending multiply");

   // Tree updates stay inside the elements in use.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_WALK_WR) |-> (k_ff <= n_wide) && (k_ff != '0))
      else $error("tree write outside the active range");

   // The power-up clear runs only in the sweep and takes no work.
   assert property (@(posedge clock) disable iff (reset)
                    init_ff |-> (state_ff == S_SWEEP) && !job_pop)
      else $error("work taken before the initial clear finished");

endmodule
